// ===== rtl/cwp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cwp_pkg: shared types and constants of the cache way partition allocator
// Field layouts, command and status codes, and the way span mask function.
// ----------------------------------------------------------------------------
package cwp_pkg;

    // sizing
    localparam int CLIENTS    = 16;
    localparam int TOTAL_WAYS = 32;
    localparam int CIDX_W     = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
    localparam int ID_CMP_W   = 9;
    localparam int WAY_W      = 6;
    localparam int MASK_W     = 32;
    localparam int LEVEL_W    = 8;

    // stream and config widths
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 112;
    localparam int CFG_ADDR_W  = 1;
    localparam int CFG_DATA_W  = 6;

    // reset values and fixed values
    localparam logic [WAY_W-1:0]   GLOBAL_LIMIT_RST = 6'd16;
    localparam logic [WAY_W-1:0]   CLIENT_LIMIT_RST = 6'd8;
    localparam logic [2:0]         FREE_RST         = 3'b110;
    localparam logic [WAY_W-1:0]   WAYS_SAT         = 6'd63;
    localparam logic [WAY_W-1:0]   TOTAL_WAYS_V     = WAY_W'(TOTAL_WAYS);
    localparam logic [LEVEL_W-1:0] LEVEL_L3         = 8'd3;

    // command codes
    typedef enum logic [1:0] {
        CMD_TAKE    = 2'd0,
        CMD_FREE    = 2'd1,
        CMD_SET     = 2'd2,
        CMD_RELEASE = 2'd3
    } cmd_e;

    // status codes
    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_LEVEL   = 3'd1,
        ST_PERM    = 3'd2,
        ST_NOSPACE = 3'd3,
        ST_RETRY   = 3'd4
    } status_e;

    // configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_GLOBAL_LIMIT = 1'd0,
        REG_CLIENT_LIMIT = 1'd1
    } reg_index_e;

    // sequencer states
    typedef enum logic {
        FSM_IDLE = 1'b0,
        FSM_EXEC = 1'b1
    } fsm_state_e;

    // one request
    typedef struct packed {
        cmd_e               cmd;
        logic [3:0]         client_id;
        logic [1:0]         class_sel;
        logic [WAY_W-1:0]   req_ways;
        logic [LEVEL_W-1:0] level;
    } item_t;

    // per-client table entry
    typedef struct packed {
        logic [2:0]       classes;
        logic [WAY_W-1:0] reserved;
    } client_entry_t;

    // class-level state
    typedef struct packed {
        logic [2:0]       free;
        logic [WAY_W-1:0] ways0;
        logic [WAY_W-1:0] ways1;
        logic [WAY_W-1:0] ways2;
    } class_state_t;

    // one result
    typedef struct packed {
        status_e           status;
        logic [1:0]        granted_class;
        logic [WAY_W-1:0]  granted_ways;
        logic              masks_changed;
        logic [MASK_W-1:0] mask_shared;
        logic [MASK_W-1:0] mask_one;
        logic [MASK_W-1:0] mask_two;
    } result_t;

    // contiguous way mask from start for n ways, clipped at the way count
    function automatic logic [MASK_W-1:0] span_mask(input logic [7:0] start,
                                                    input logic [WAY_W-1:0] n);
        logic [MASK_W-1:0] m;
        logic [8:0]        stop;
        stop = {1'b0, start} + {3'b000, n};
        for (int i = 0; i < MASK_W; i++) begin
            m[i] = (9'(i) >= {1'b0, start}) && (9'(i) < stop) && (i < TOTAL_WAYS);
        end
        return m;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/cwp_client_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cwp_client_ram: per-client class and reservation table
// Synchronous memory with one read and one write port, registered read data,
// and per-entry valid bits so that unwritten entries read as zero.
// ----------------------------------------------------------------------------
module cwp_client_ram (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     rd_en,
    input  wire logic [cwp_pkg::CIDX_W-1:0] rd_addr,
    output cwp_pkg::client_entry_t        rd_data,
    input  wire logic                     wr_en,
    input  wire logic [cwp_pkg::CIDX_W-1:0] wr_addr,
    input  wire cwp_pkg::client_entry_t   wr_data
);

    cwp_pkg::client_entry_t              mem [cwp_pkg::CLIENTS];
    logic [cwp_pkg::CLIENTS-1:0]         valid_reg;
    cwp_pkg::client_entry_t              rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // valid bits, cleared at reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // registered read, entries never written read as zero
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= valid_reg[rd_addr] ? mem[rd_addr] : '0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ===== rtl/cwp_alloc_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cwp_alloc_core: request decision logic
// Evaluates one command against the class state and the client entry and
// gives the updated state, the updated entry and the result with new masks.
// ----------------------------------------------------------------------------
module cwp_alloc_core (
    input  wire cwp_pkg::item_t               item,
    input  wire cwp_pkg::class_state_t        cls_st,
    input  wire cwp_pkg::client_entry_t       entry,
    input  wire logic [cwp_pkg::WAY_W-1:0]    way_cap_all,
    input  wire logic [cwp_pkg::WAY_W-1:0]    way_cap_client,
    output cwp_pkg::class_state_t             cls_next,
    output cwp_pkg::client_entry_t            entry_next,
    output logic                              client_ok,
    output cwp_pkg::result_t                  res
);

    logic [cwp_pkg::WAY_W-1:0] ways_sel;
    logic [2:0]                sel_bit;
    logic                      owned_sel;
    logic [6:0]                rel_sum0;
    logic [cwp_pkg::WAY_W-1:0] rel_ways0;
    logic [cwp_pkg::WAY_W-1:0] rel_reserved;
    logic [cwp_pkg::WAY_W-1:0] occupied;
    logic [cwp_pkg::WAY_W-1:0] lim_g;
    logic [cwp_pkg::WAY_W-1:0] lim_l;
    logic [cwp_pkg::WAY_W-1:0] lim_gl;
    logic [cwp_pkg::WAY_W-1:0] lim;
    logic [cwp_pkg::WAY_W-1:0] n1;
    logic [cwp_pkg::WAY_W-1:0] n2;
    logic [6:0]                rc_tot;
    logic [7:0]                rc_sum0;
    logic [cwp_pkg::WAY_W-1:0] rc_ways0;
    logic [cwp_pkg::WAY_W-1:0] rc_reserved;
    logic [2:0]                take_bit;
    logic [1:0]                take_cls;
    logic [7:0]                start_two;

    // client range check
    assign client_ok = (cwp_pkg::ID_CMP_W'(item.client_id)
                        < cwp_pkg::ID_CMP_W'(cwp_pkg::CLIENTS));

    // addressed class
    always_comb begin
        case (item.class_sel)
            2'd1: begin
                ways_sel = cls_st.ways1;
                sel_bit  = 3'b010;
            end
            2'd2: begin
                ways_sel = cls_st.ways2;
                sel_bit  = 3'b100;
            end
            default: begin
                ways_sel = '0;
                sel_bit  = 3'b000;
            end
        endcase
    end
    assign owned_sel = |(sel_bit & entry.classes);

    // ways of the addressed class back to the shared class
    assign rel_sum0     = {1'b0, cls_st.ways0} + {1'b0, ways_sel};
    assign rel_ways0    = (rel_sum0 > 7'(cwp_pkg::WAYS_SAT)) ? cwp_pkg::WAYS_SAT
                                                              : rel_sum0[5:0];
    assign rel_reserved = (entry.reserved >= ways_sel) ? entry.reserved - ways_sel : '0;

    // reservation limit
    assign occupied = (cls_st.ways0 < cwp_pkg::TOTAL_WAYS_V)
                      ? cwp_pkg::TOTAL_WAYS_V - cls_st.ways0 : '0;
    assign lim_g    = (way_cap_all > occupied) ? way_cap_all - occupied : '0;
    assign lim_l    = (way_cap_client > entry.reserved)
                      ? way_cap_client - entry.reserved : '0;
    assign lim_gl   = (lim_g < lim_l) ? lim_g : lim_l;
    assign lim      = (lim_gl > cls_st.ways0) ? cls_st.ways0 : lim_gl;

    // release of every owned class
    assign n1          = entry.classes[1] ? cls_st.ways1 : '0;
    assign n2          = entry.classes[2] ? cls_st.ways2 : '0;
    assign rc_tot      = {1'b0, n1} + {1'b0, n2};
    assign rc_sum0     = {2'b00, cls_st.ways0} + {1'b0, rc_tot};
    assign rc_ways0    = (rc_sum0 > 8'(cwp_pkg::WAYS_SAT)) ? cwp_pkg::WAYS_SAT
                                                            : rc_sum0[5:0];
    assign rc_reserved = ({1'b0, entry.reserved} >= rc_tot)
                         ? entry.reserved - rc_tot[5:0] : '0;

    // lowest free class
    always_comb begin
        if (cls_st.free[0]) begin
            take_bit = 3'b001;
            take_cls = 2'd0;
        end else if (cls_st.free[1]) begin
            take_bit = 3'b010;
            take_cls = 2'd1;
        end else begin
            take_bit = 3'b100;
            take_cls = 2'd2;
        end
    end

    // command evaluation
    always_comb begin
        cls_next          = cls_st;
        entry_next        = entry;
        res.status        = cwp_pkg::ST_OK;
        res.granted_class = '0;
        res.granted_ways  = '0;
        res.masks_changed = 1'b0;
        if (!client_ok) begin
            res.status = cwp_pkg::ST_PERM;
        end else begin
            case (item.cmd)
                cwp_pkg::CMD_TAKE: begin
                    if (cls_st.free == 3'b000) begin
                        res.status = cwp_pkg::ST_NOSPACE;
                    end else begin
                        entry_next.classes = entry.classes | take_bit;
                        cls_next.free      = cls_st.free & ~take_bit;
                        res.granted_class  = take_cls;
                    end
                end
                cwp_pkg::CMD_FREE: begin
                    if (owned_sel) begin
                        if (ways_sel != '0) begin
                            entry_next.reserved = rel_reserved;
                            cls_next.ways0      = rel_ways0;
                            if (item.class_sel == 2'd1) begin
                                cls_next.ways1 = '0;
                            end else begin
                                cls_next.ways2 = '0;
                            end
                            res.masks_changed = 1'b1;
                        end
                        entry_next.classes = entry.classes & ~sel_bit;
                        cls_next.free      = cls_st.free | sel_bit;
                    end else begin
                        res.status = cwp_pkg::ST_PERM;
                    end
                end
                cwp_pkg::CMD_SET: begin
                    if (item.level != cwp_pkg::LEVEL_L3) begin
                        res.status = cwp_pkg::ST_LEVEL;
                    end else if (!owned_sel) begin
                        res.status = cwp_pkg::ST_PERM;
                    end else if (item.req_ways == '0) begin
                        if (ways_sel != '0) begin
                            entry_next.reserved = rel_reserved;
                            cls_next.ways0      = rel_ways0;
                            if (item.class_sel == 2'd1) begin
                                cls_next.ways1 = '0;
                            end else begin
                                cls_next.ways2 = '0;
                            end
                            res.masks_changed = 1'b1;
                        end
                    end else if (lim == '0) begin
                        res.status = cwp_pkg::ST_NOSPACE;
                    end else if (item.req_ways > lim) begin
                        res.status       = cwp_pkg::ST_RETRY;
                        res.granted_ways = lim;
                    end else begin
                        entry_next.reserved = entry.reserved + item.req_ways;
                        cls_next.ways0      = cls_st.ways0 - item.req_ways;
                        if (item.class_sel == 2'd1) begin
                            cls_next.ways1 = item.req_ways;
                        end else begin
                            cls_next.ways2 = item.req_ways;
                        end
                        res.masks_changed = 1'b1;
                        res.granted_ways  = item.req_ways;
                    end
                end
                cwp_pkg::CMD_RELEASE: begin
                    cls_next.free       = cls_st.free | (entry.classes & 3'b110);
                    entry_next.reserved = rc_reserved;
                    entry_next.classes  = '0;
                    if (entry.classes[1]) begin
                        cls_next.ways1 = '0;
                    end
                    if (entry.classes[2]) begin
                        cls_next.ways2 = '0;
                    end
                    if (rc_tot != '0) begin
                        cls_next.ways0    = rc_ways0;
                        res.masks_changed = 1'b1;
                    end
                end
                default: begin
                    res.status = cwp_pkg::ST_OK;
                end
            endcase
        end
        // masks follow the class ways, packed from way 0 upward
        start_two       = {2'b00, cls_next.ways0} + {2'b00, cls_next.ways1};
        res.mask_shared = cwp_pkg::span_mask(8'd0, cls_next.ways0);
        res.mask_one    = cwp_pkg::span_mask({2'b00, cls_next.ways0}, cls_next.ways1);
        res.mask_two    = cwp_pkg::span_mask(start_two, cls_next.ways2);
    end

endmodule
`default_nettype wire

// ===== rtl/cache_way_partition_allocator.sv =====
// Result: an accepted request is evaluated in the execute state, which waits
//   while a result is held; the result then stays until the output side takes it.
// Flow: a new request is accepted only in the idle state, after the last one
//   is executed, as the client table is read on accept and written on execute.
// Reset: synchronous, active low; limits go to 16 and 8, class 0 holds every
//   way, classes 1 and 2 are free and all client entries read as zero.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cache_way_partition_allocator: service class and way reservation manager
// Stream requests in, one result per request out; client table in a
// synchronous memory, read on accept and written back on execute.
// ----------------------------------------------------------------------------
module cache_way_partition_allocator (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // config write port
    input  wire logic                               cfg_wr_en,
    input  wire logic [cwp_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [cwp_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // request stream
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // s_tdata: cmd[1:0], client_id[5:2], class_sel[7:6], req_ways[13:8],
    //          level[21:14], zero fill[23:22]
    input  wire logic [cwp_pkg::IN_TDATA_W-1:0]     s_tdata,
    // result stream
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // m_tdata: status[2:0], granted_class[4:3], granted_ways[10:5],
    //          masks_changed[11], mask_shared[43:12], mask_one[75:44],
    //          mask_two[107:76], zero fill[111:108]
    output logic [cwp_pkg::OUT_TDATA_W-1:0]         m_tdata
);

    cwp_pkg::fsm_state_e             state_reg;
    cwp_pkg::fsm_state_e             state_next;
    logic [cwp_pkg::WAY_W-1:0]       way_cap_all_reg;
    logic [cwp_pkg::WAY_W-1:0]       way_cap_client_reg;
    cwp_pkg::class_state_t           cls_reg;
    cwp_pkg::class_state_t           cls_next;
    cwp_pkg::item_t                  item_reg;
    cwp_pkg::item_t                  s_item;
    cwp_pkg::client_entry_t          entry_rd;
    cwp_pkg::client_entry_t          entry_next;
    cwp_pkg::result_t                res;
    logic                            client_ok;
    logic                            s_fire;
    logic                            exec_go;
    logic                            ram_we;
    logic                            m_tvalid_reg;
    logic [cwp_pkg::OUT_TDATA_W-1:0] m_tdata_reg;

    // request field unpacking
    assign s_item.cmd       = cwp_pkg::cmd_e'(s_tdata[1:0]);
    assign s_item.client_id = s_tdata[5:2];
    assign s_item.class_sel = s_tdata[7:6];
    assign s_item.req_ways  = s_tdata[13:8];
    assign s_item.level     = s_tdata[21:14];

    assign s_fire = s_tvalid && s_tready;
    assign ram_we = exec_go && client_ok;

    // sequencer state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cwp_pkg::FSM_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // sequencer next state and strobes
    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        exec_go    = 1'b0;
        case (state_reg)
            cwp_pkg::FSM_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = cwp_pkg::FSM_EXEC;
                end
            end
            cwp_pkg::FSM_EXEC: begin
                exec_go = !m_tvalid_reg || m_tready;
                if (exec_go) begin
                    state_next = cwp_pkg::FSM_IDLE;
                end
            end
            default: begin
                state_next = cwp_pkg::FSM_IDLE;
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            way_cap_all_reg    <= cwp_pkg::GLOBAL_LIMIT_RST;
            way_cap_client_reg <= cwp_pkg::CLIENT_LIMIT_RST;
        end else if (cfg_wr_en) begin
            case (cwp_pkg::reg_index_e'(cfg_addr))
                cwp_pkg::REG_GLOBAL_LIMIT: way_cap_all_reg <= cfg_wdata;
                cwp_pkg::REG_CLIENT_LIMIT: way_cap_client_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // request capture
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            item_reg <= s_item;
        end
    end

    // client table
    cwp_client_ram u_client_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (s_fire),
        .rd_addr (cwp_pkg::CIDX_W'(s_item.client_id)),
        .rd_data (entry_rd),
        .wr_en   (ram_we),
        .wr_addr (cwp_pkg::CIDX_W'(item_reg.client_id)),
        .wr_data (entry_next)
    );

    // decision logic
    cwp_alloc_core u_alloc_core (
        .item           (item_reg),
        .cls_st         (cls_reg),
        .entry          (entry_rd),
        .way_cap_all    (way_cap_all_reg),
        .way_cap_client (way_cap_client_reg),
        .cls_next       (cls_next),
        .entry_next     (entry_next),
        .client_ok      (client_ok),
        .res            (res)
    );

    // class state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cls_reg.free  <= cwp_pkg::FREE_RST;
            cls_reg.ways0 <= cwp_pkg::TOTAL_WAYS_V;
            cls_reg.ways1 <= '0;
            cls_reg.ways2 <= '0;
        end else if (exec_go) begin
            cls_reg <= cls_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (exec_go) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (exec_go) begin
            m_tdata_reg <= {4'b0000, res.mask_two, res.mask_one, res.mask_shared,
                            res.masks_changed, res.granted_ways, res.granted_class,
                            res.status};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTH
    // the shared class is never handed out
    a_shared_never_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cls_reg.free[0] == 1'b0)
        else $error("shared class marked free");

    // a free class holds no ways
    a_free_class_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (!cls_reg.free[1] || cls_reg.ways1 == '0) &&
        (!cls_reg.free[2] || cls_reg.ways2 == '0))
        else $error("free class still holds ways");

    // an accepted request moves to execute
    a_accept_to_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> state_reg == cwp_pkg::FSM_EXEC)
        else $error("accepted request not executed");

    // table write back only while executing
    a_write_in_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> state_reg == cwp_pkg::FSM_EXEC)
        else $error("client table written outside execute");

    // every executed request presents a result
    a_exec_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        exec_go |=> m_tvalid_reg)
        else $error("executed request gave no result");
`endif

endmodule
`default_nettype wire
